// File: src/stt_pkg.sv
// Shared types and constants of the software timer table.
package stt_pkg;

    localparam int SLOTS  = 16;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int CNT_OUT_W = 5;

    localparam int IN_DATA_W  = 120;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 56;
    localparam int OUT_USER_W = 3;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_ADD   = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        KIND_FIRED   = 3'd0,
        KIND_ADDED   = 3'd1,
        KIND_FULL    = 3'd2,
        KIND_CLEARED = 3'd3,
        KIND_IDLE    = 3'd4
    } t_kind;

    typedef struct packed {
        logic [31:0] accum;
        logic [31:0] period;
        logic        once;
        logic [15:0] callback;
        logic [31:0] param;
    } t_slot;

    typedef struct packed {
        logic  valid;
        t_slot slot;
    } t_entry;

    // Controls broadcast to every cell of the chain.
    typedef struct packed {
        logic shift;   // pop head, move every entry one cell toward the head
        logic ins;     // re-append the processed head entry at the tail
        logic add;     // append a new entry at the first free cell
    } t_cell_ctl;

    typedef struct packed {
        logic  keep;
        logic  fire;
        t_slot slot;
    } t_head_res;

endpackage

// File: src/stt_cell.sv
// One timer slot of the chain; takes its right neighbor's entry on a shift.
module stt_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stt_pkg::t_cell_ctl i_ctl,
    input  stt_pkg::t_slot     i_ins,
    input  logic               i_left_valid,
    input  stt_pkg::t_entry    i_right,
    output stt_pkg::t_entry    o_entry
);
    import stt_pkg::*;

    logic  r_valid;
    t_slot r_slot;
    logic  n_valid;
    t_slot n_slot;

    always_comb begin
        n_valid = r_valid;
        n_slot  = r_slot;
        if (i_ctl.shift) begin
            // the cell that becomes the tail takes the re-appended entry
            if (!i_right.valid && r_valid && i_ctl.ins) begin
                n_valid = 1'b1;
                n_slot  = i_ins;
            end else begin
                n_valid = i_right.valid;
                n_slot  = i_right.slot;
            end
        end else if (i_ctl.add && !r_valid && i_left_valid) begin
            n_valid = 1'b1;
            n_slot  = i_ins;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_entry.valid = r_valid;
    assign o_entry.slot  = r_slot;

endmodule

// File: src/stt_head.sv
// Head unit: updates the timer at the head of the chain for tick or clear.
module stt_head (
    input  stt_pkg::t_slot     i_slot,
    input  stt_pkg::t_op       i_op,
    input  logic [31:0]        i_delta,
    input  logic [15:0]        i_tag,
    output stt_pkg::t_head_res o_res
);
    import stt_pkg::*;

    logic [32:0] w_sum;
    logic [31:0] w_acc;
    logic        w_hit;

    assign w_sum = {1'b0, i_slot.accum} + {1'b0, i_delta};
    assign w_acc = w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];
    assign w_hit = (w_acc >= i_slot.period);

    always_comb begin
        o_res.keep = 1'b1;
        o_res.fire = 1'b0;
        o_res.slot = i_slot;
        unique case (i_op)
            OP_TICK: begin
                o_res.fire       = w_hit;
                o_res.keep       = !(w_hit && i_slot.once);
                o_res.slot.accum = w_hit ? 32'd0 : w_acc;
            end
            OP_CLEAR: begin
                o_res.keep = !((i_tag != 16'd0) && (i_slot.callback == i_tag));
            end
            default: begin
                o_res.keep = 1'b1;
            end
        endcase
    end

endmodule

// File: src/software_timer_table_unit.sv
// Top level of the software timer table: cell chain, head unit and sequencer.
//
// Input beats carry one command: tuser holds the opcode (tick, add, clear),
// tdata the tick delta, the new timer's period, callback tag, parameter tag
// and one-shot flag. Output beats carry one result each; tuser holds its kind
// and tlast marks the final result of a command.
// The timers sit in a chain of cells in insertion order. An add writes the
// first free cell in the accept cycle; its result is on the output in the
// next cycle. A tick or a clear walks the chain: each cycle that the output
// register can take a beat, the head timer is popped, updated by the head
// unit, and appended again at the tail unless it is removed, so each timer
// is visited once before the closing beat. A fired timer is held until the
// next one fires, which lets the last one carry tlast. After the closing beat
// is loaded the sequencer returns to idle, where the next command is taken.
// Input is taken only while no command is in progress.
// When the receiver stalls, the walk holds with the pending beat in the
// output register. Reset empties the table at once and drops any beat.
module software_timer_table_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // delta_ms, period_ms, callback_tag, param_tag, one_shot, zero fill
    input  logic [stt_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // opcode
    input  logic [stt_pkg::IN_USER_W-1:0]     i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // fired_callback, fired_param, removed_count, zero fill
    output logic [stt_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // kind
    output logic [stt_pkg::OUT_USER_W-1:0]    o_m_axis_tuser,
    output logic                              o_m_axis_tlast
);
    import stt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    t_state         r_state;
    t_op            r_op;
    logic [31:0]    r_delta;
    logic [15:0]    r_tag;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_left;
    logic [CNT_W-1:0] r_removed;
    logic           r_pend_valid;
    logic [15:0]    r_pend_cb;
    logic [31:0]    r_pend_param;
    logic           r_out_valid;
    t_kind          r_out_kind;
    logic [15:0]    r_out_cb;
    logic [31:0]    r_out_param;
    logic [CNT_OUT_W-1:0] r_out_cnt;
    logic           r_out_last;

    t_entry         w_cell  [SLOTS];
    t_entry         w_right [SLOTS];
    logic           w_left_valid [SLOTS];
    t_cell_ctl      w_ctl;
    t_slot          w_new;
    t_slot          w_ins;
    t_head_res      w_head;
    t_op            w_in_op;
    logic           w_out_free;
    logic           w_accept;
    logic           w_step;
    logic           w_full;
    logic           w_load;
    logic [CNT_OUT_W-1:0] w_rem_sat;

    assign w_in_op    = t_op'(i_s_axis_tuser);
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_step     = (r_state == ST_RUN) && w_out_free;
    assign w_full     = w_cell[SLOTS-1].valid;

    assign w_new.accum    = 32'd0;
    assign w_new.period   = i_s_axis_tdata[63:32];
    assign w_new.callback = i_s_axis_tdata[79:64];
    assign w_new.param    = i_s_axis_tdata[111:80];
    assign w_new.once     = i_s_axis_tdata[112];

    stt_head u_head (
        .i_slot  (w_cell[0].slot),
        .i_op    (r_op),
        .i_delta (r_delta),
        .i_tag   (r_tag),
        .o_res   (w_head)
    );

    assign w_ins       = (r_state == ST_RUN) ? w_head.slot : w_new;
    assign w_ctl.shift = w_step;
    assign w_ctl.ins   = w_step && w_head.keep;
    assign w_ctl.add   = w_accept && (w_in_op == OP_ADD);

    // a new beat enters the output register this cycle
    assign w_load = w_ctl.add || (w_step && w_head.fire && r_pend_valid) ||
                    ((r_state == ST_DONE) && w_out_free);

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        if (g == SLOTS - 1) begin : g_tail
            assign w_right[g] = '0;
        end else begin : g_mid
            assign w_right[g] = w_cell[g+1];
        end
        if (g == 0) begin : g_first
            assign w_left_valid[g] = 1'b1;
        end else begin : g_rest
            assign w_left_valid[g] = w_cell[g-1].valid;
        end
        stt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_ins        (w_ins),
            .i_left_valid (w_left_valid[g]),
            .i_right      (w_right[g]),
            .o_entry      (w_cell[g])
        );
    end

    assign w_rem_sat = ({{(32-CNT_W){1'b0}}, r_removed} > 32'd31) ?
                       CNT_OUT_W'(31) : CNT_OUT_W'(r_removed);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && i_m_axis_tready && !w_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_op         <= w_in_op;
                        r_delta      <= i_s_axis_tdata[31:0];
                        r_tag        <= i_s_axis_tdata[79:64];
                        r_left       <= r_count;
                        r_removed    <= '0;
                        r_pend_valid <= 1'b0;
                        unique case (w_in_op)
                            OP_ADD: begin
                                r_out_valid <= 1'b1;
                                r_out_kind  <= w_full ? KIND_FULL : KIND_ADDED;
                                r_out_cb    <= '0;
                                r_out_param <= '0;
                                r_out_cnt   <= '0;
                                r_out_last  <= 1'b1;
                                if (!w_full) begin
                                    r_count <= r_count + CNT_W'(1);
                                end
                            end
                            OP_TICK, OP_CLEAR: begin
                                r_state <= (r_count == '0) ? ST_DONE : ST_RUN;
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_RUN: begin
                    if (w_step) begin
                        r_left <= r_left - CNT_W'(1);
                        if (!w_head.keep) begin
                            r_count <= r_count - CNT_W'(1);
                            if (r_op == OP_CLEAR) begin
                                r_removed <= r_removed + CNT_W'(1);
                            end
                        end
                        if (w_head.fire) begin
                            // release the previous firing, hold this one
                            if (r_pend_valid) begin
                                r_out_valid <= 1'b1;
                                r_out_kind  <= KIND_FIRED;
                                r_out_cb    <= r_pend_cb;
                                r_out_param <= r_pend_param;
                                r_out_cnt   <= '0;
                                r_out_last  <= 1'b0;
                            end
                            r_pend_valid <= 1'b1;
                            r_pend_cb    <= w_cell[0].slot.callback;
                            r_pend_param <= w_cell[0].slot.param;
                        end
                        if (r_left == CNT_W'(1)) begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_last  <= 1'b1;
                        if (r_op == OP_CLEAR) begin
                            r_out_kind  <= KIND_CLEARED;
                            r_out_cb    <= '0;
                            r_out_param <= '0;
                            r_out_cnt   <= w_rem_sat;
                        end else if (r_pend_valid) begin
                            r_out_kind  <= KIND_FIRED;
                            r_out_cb    <= r_pend_cb;
                            r_out_param <= r_pend_param;
                            r_out_cnt   <= '0;
                        end else begin
                            r_out_kind  <= KIND_IDLE;
                            r_out_cb    <= '0;
                            r_out_param <= '0;
                            r_out_cnt   <= '0;
                        end
                        r_pend_valid <= 1'b0;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {3'b000, r_out_cnt, r_out_param, r_out_cb};

endmodule

// File: src/stt_checker.sv
// Port-level checks of the software timer table, bound to the top level.
module stt_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_m_axis_tready,
    input logic                              o_m_axis_tvalid,
    input logic [stt_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    input logic [stt_pkg::OUT_USER_W-1:0]    o_m_axis_tuser,
    input logic                              o_m_axis_tlast
);
    import stt_pkg::*;

    // a stalled result beat holds its kind and last flag
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast))
        else $error("result beat changed while stalled");

    // every kind but a firing is the single answer to its command
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser != KIND_FIRED) |-> o_m_axis_tlast)
        else $error("non-fire result without last");

    // callback and parameter only travel with a firing
    a_fire_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser != KIND_FIRED) |->
            (o_m_axis_tdata[47:0] == 48'd0))
        else $error("fire fields set on a non-fire result");

    // removed count only travels with a clear answer
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser != KIND_CLEARED) |->
            (o_m_axis_tdata[52:48] == 5'd0))
        else $error("removed count set on a non-clear result");

endmodule

bind software_timer_table_unit stt_checker u_stt_checker (.*);

// File: tb/sv/tb_software_timer_table_unit.sv
// Testbench of the software timer table: directed and random commands, checked beat by beat.
`timescale 1ns / 1ps

module tb_software_timer_table_unit;
    import stt_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] delta;
        logic [31:0] period;
        logic [15:0] callback;
        logic [31:0] param;
        logic        once;
    } t_cmd;

    typedef struct {
        t_kind       kind;
        logic [15:0] callback;
        logic [31:0] param;
        logic [4:0]  removed;
        logic        last;
    } t_timer_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  i_s_axis_tuser = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [OUT_USER_W-1:0] o_m_axis_tuser;
    logic                  o_m_axis_tlast;

    software_timer_table_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Timer table as the block should hold it.
    logic        tm_valid [SLOTS];
    logic [31:0] tm_accum [SLOTS];
    logic [31:0] tm_period [SLOTS];
    logic        tm_once [SLOTS];
    logic [15:0] tm_callback [SLOTS];
    logic [31:0] tm_param [SLOTS];

    t_cmd          cmd_backlog[$];
    t_timer_result pending_results[$];

    int   mismatch_cnt = 0;
    int   tx_idle_pct = 19;
    int   rx_idle_pct = 68;
    int   hold_len = 0;
    int   hold_req = 0;
    logic cmd_taken = 1'b0;

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatch_cnt++;
    endtask

    task automatic queue_result(input t_timer_result r);
        pending_results = {pending_results, r};
    endtask

    task automatic queue_cmd(input t_cmd c);
        cmd_backlog = {cmd_backlog, c};
    endtask

    function automatic t_timer_result make_result(input t_kind kind, input logic [15:0] cb,
                                                  input logic [31:0] par,
                                                  input logic [4:0] cnt, input logic last);
        t_timer_result r;
        r.kind     = kind;
        r.callback = cb;
        r.param    = par;
        r.removed  = cnt;
        r.last     = last;
        return r;
    endfunction

    task automatic move_timer(input int dst, input int src);
        tm_valid[dst]    = tm_valid[src];
        tm_accum[dst]    = tm_accum[src];
        tm_period[dst]   = tm_period[src];
        tm_once[dst]     = tm_once[src];
        tm_callback[dst] = tm_callback[src];
        tm_param[dst]    = tm_param[src];
    endtask

    // Update the table for one accepted command and queue the beats it causes.
    task automatic apply_command(input t_cmd c);
        int            i;
        int            w;
        int            removed;
        logic [32:0]   sum;
        logic [31:0]   acc;
        logic          keep;
        t_timer_result fired[$];
        case (c.op)
            OP_ADD: begin
                i = 0;
                while (i < SLOTS && tm_valid[i])
                    i++;
                if (i == SLOTS) begin
                    queue_result(make_result(KIND_FULL, '0, '0, '0, 1'b1));
                end else begin
                    tm_valid[i]    = 1'b1;
                    tm_accum[i]    = '0;
                    tm_period[i]   = c.period;
                    tm_once[i]     = c.once;
                    tm_callback[i] = c.callback;
                    tm_param[i]    = c.param;
                    queue_result(make_result(KIND_ADDED, '0, '0, '0, 1'b1));
                end
            end
            OP_CLEAR: begin
                w = 0;
                removed = 0;
                for (i = 0; i < SLOTS; i++) begin
                    if (tm_valid[i]) begin
                        if (c.callback != 16'd0 && tm_callback[i] == c.callback) begin
                            removed++;
                        end else begin
                            move_timer(w, i);
                            w++;
                        end
                    end
                end
                for (i = w; i < SLOTS; i++)
                    tm_valid[i] = 1'b0;
                if (removed > 31)
                    removed = 31;
                queue_result(make_result(KIND_CLEARED, '0, '0, removed[4:0], 1'b1));
            end
            OP_TICK: begin
                w = 0;
                for (i = 0; i < SLOTS; i++) begin
                    if (tm_valid[i]) begin
                        sum = {1'b0, tm_accum[i]} + {1'b0, c.delta};
                        acc = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                        keep = 1'b1;
                        if (acc >= tm_period[i]) begin
                            fired = {fired, make_result(KIND_FIRED, tm_callback[i],
                                                        tm_param[i], '0, 1'b0)};
                            if (tm_once[i])
                                keep = 1'b0;
                            else
                                acc = '0;
                        end
                        if (keep) begin
                            move_timer(w, i);
                            tm_accum[w] = acc;
                            w++;
                        end
                    end
                end
                for (i = w; i < SLOTS; i++)
                    tm_valid[i] = 1'b0;
                if (fired.size() == 0) begin
                    queue_result(make_result(KIND_IDLE, '0, '0, '0, 1'b1));
                end else begin
                    for (i = 0; i < fired.size(); i++) begin
                        fired[i].last = (i == fired.size() - 1);
                        queue_result(fired[i]);
                    end
                end
            end
            default: begin
                // unused opcode: no beat, no state change
            end
        endcase
    endtask

    task automatic check_result();
        t_timer_result e;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected beat, kind %0d", o_m_axis_tuser));
        end else begin
            e = pending_results.pop_front();
            if (o_m_axis_tuser !== e.kind)
                report_mismatch($sformatf("kind %0d, want %0d", o_m_axis_tuser, e.kind));
            if (o_m_axis_tdata[15:0] !== e.callback)
                report_mismatch($sformatf("callback %h, want %h",
                                          o_m_axis_tdata[15:0], e.callback));
            if (o_m_axis_tdata[47:16] !== e.param)
                report_mismatch($sformatf("param %h, want %h",
                                          o_m_axis_tdata[47:16], e.param));
            if (o_m_axis_tdata[52:48] !== e.removed)
                report_mismatch($sformatf("removed %0d, want %0d",
                                          o_m_axis_tdata[52:48], e.removed));
            if (o_m_axis_tlast !== e.last)
                report_mismatch($sformatf("tlast %b, want %b", o_m_axis_tlast, e.last));
        end
    endtask

    // Sample both sides at the rising edge.
    always @(posedge i_clk) begin : monitor
        t_cmd c;
        if (!i_rst_n) begin
            cmd_taken <= 1'b0;
        end else begin
            cmd_taken <= i_s_axis_tvalid && o_s_axis_tready;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                c.op       = i_s_axis_tuser;
                c.delta    = i_s_axis_tdata[31:0];
                c.period   = i_s_axis_tdata[63:32];
                c.callback = i_s_axis_tdata[79:64];
                c.param    = i_s_axis_tdata[111:80];
                c.once     = i_s_axis_tdata[112];
                apply_command(c);
            end
            if (o_m_axis_tvalid && i_m_axis_tready)
                check_result();
        end
    end

    // Offer the next command once the current beat is gone.
    always @(negedge i_clk) begin : driver
        t_cmd c;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || cmd_taken) begin
            if (cmd_backlog.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                c = cmd_backlog.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tuser  <= c.op;
                i_s_axis_tdata  <= {7'd0, c.once, c.param, c.callback, c.period, c.delta};
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus long holds on request.
    always @(negedge i_clk) begin : receiver
        int hold_left;
        int hold_ack;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            hold_left = 0;
            hold_ack  = hold_req;
        end else if (hold_req != hold_ack) begin
            hold_ack  = hold_req;
            hold_left = hold_len;
            i_m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic t_cmd make_cmd(input logic [1:0] op, input logic [31:0] delta,
                                      input logic [31:0] period, input logic [15:0] cb,
                                      input logic [31:0] par, input logic once);
        t_cmd c;
        c.op       = op;
        c.delta    = delta;
        c.period   = period;
        c.callback = cb;
        c.param    = par;
        c.once     = once;
        return c;
    endfunction

    // Mostly small periods and deltas so timers fire often; a few full-range values.
    function automatic t_cmd random_command();
        int          pick;
        logic [15:0] cb;
        logic [31:0] delta;
        logic [31:0] period;
        logic [1:0]  op;
        pick = $urandom_range(99);
        case ($urandom_range(7))
            0: cb = 16'($urandom);
            1: cb = 16'h0000;
            2: cb = 16'h0001;
            3: cb = 16'h0002;
            4: cb = 16'h8000;
            default: cb = 16'h0003;
        endcase
        case ($urandom_range(9))
            0: delta = $urandom;
            1, 2: delta = $urandom_range(100);
            default: delta = $urandom_range(6);
        endcase
        case ($urandom_range(9))
            0: period = $urandom;
            1, 2: period = $urandom_range(200);
            default: period = $urandom_range(12);
        endcase
        if (pick < 42)
            op = OP_ADD;
        else if (pick < 84)
            op = OP_TICK;
        else if (pick < 96)
            op = OP_CLEAR;
        else
            op = OP_UNUSED;
        return make_cmd(op, delta, period, cb, $urandom, 1'($urandom_range(1)));
    endfunction

    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || i_s_axis_tvalid || pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin : stimulus
        int i;
        int ph;
        for (i = 0; i < SLOTS; i++)
            tm_valid[i] = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty tick, unused opcode, period zero with callback zero,
        // saturating accumulator, clear by tag zero, full table, wide clear.
        queue_cmd(make_cmd(OP_TICK, 32'd0, '0, '0, '0, 1'b0));
        queue_cmd(make_cmd(OP_UNUSED, '1, '1, '1, '1, 1'b1));
        queue_cmd(make_cmd(OP_ADD, '0, 32'd0, 16'h0000, 32'hFFFF_FFFF, 1'b1));
        queue_cmd(make_cmd(OP_ADD, '0, 32'hFFFF_FFFF, 16'hFFFF, 32'd0, 1'b0));
        queue_cmd(make_cmd(OP_TICK, 32'd0, '0, '0, '0, 1'b0));
        queue_cmd(make_cmd(OP_TICK, 32'h8000_0000, '0, '0, '0, 1'b0));
        queue_cmd(make_cmd(OP_TICK, 32'h8000_0000, '0, '0, '0, 1'b0));
        queue_cmd(make_cmd(OP_CLEAR, '0, '0, 16'h0000, '0, 1'b0));
        queue_cmd(make_cmd(OP_CLEAR, '0, '0, 16'hFFFF, '0, 1'b0));
        for (i = 0; i < SLOTS; i++)
            queue_cmd(make_cmd(OP_ADD, '0, $urandom_range(5), 16'h0007,
                               $urandom, 1'b0));
        queue_cmd(make_cmd(OP_ADD, '0, 32'd1, 16'h0001, 32'd1, 1'b1));
        queue_cmd(make_cmd(OP_TICK, 32'd5, '0, '0, '0, 1'b0));
        queue_cmd(make_cmd(OP_CLEAR, '0, '0, 16'h0007, '0, 1'b0));
        wait_drained();

        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 19; rx_idle_pct = 68; end
                1: begin tx_idle_pct = 68; rx_idle_pct = 19; end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    // Stall the output long enough for the block to refuse input.
                    hold_len = 300;
                    hold_req = hold_req + 1;
                    for (i = 0; i < 8; i++)
                        queue_cmd(make_cmd(OP_ADD, '0, $urandom_range(3),
                                           16'($urandom_range(3)), $urandom,
                                           1'($urandom_range(1))));
                    for (i = 0; i < 12; i++)
                        queue_cmd(make_cmd(OP_TICK, $urandom_range(3), '0,
                                           '0, '0, 1'b0));
                    wait_drained();
                end
            endcase
            for (i = 0; i < 90; i++)
                queue_cmd(random_command());
            wait_drained();
        end

        // Let any stray beat show up before the verdict.
        repeat (4 * SLOTS) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_results.size() == 0) begin
            $display("tb_software_timer_table_unit OK");
        end else begin
            $display("tb_software_timer_table_unit NOT OK");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("tb_software_timer_table_unit NOT OK");
        $finish;
    end

endmodule
